>>> sv/cbec_pkg.sv
// Package with the types and constants of the cell balancer enable control.
`default_nettype none

package cbec_pkg;

    // Charger states as reported once per tick.
    typedef enum logic [2:0] {
        CHG_STANDBY     = 3'd0,
        CHG_DISCHARGING = 3'd1,
        CHG_PRECHARGE   = 3'd2,
        CHG_CC          = 3'd3,
        CHG_CV          = 3'd4,
        CHG_DONE        = 3'd5,
        CHG_WAIT        = 3'd6,
        CHG_OTHER       = 3'd7
    } charger_state_t;

    // Balance modes.
    typedef enum logic [1:0] {
        MODE_DISABLED    = 2'd0,
        MODE_ALWAYS      = 2'd1,
        MODE_CHARGE      = 2'd2,
        MODE_CHG_DISCHG  = 2'd3
    } balance_mode_t;

    // Register indexes of the configuration port.
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 16;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_EXTENDED_BALANCE_ON     = 3'd0,
        REG_BALANCE_MODE            = 3'd1,
        REG_ENABLE_VOLTAGE_MV       = 3'd2,
        REG_CV_OFF_TICKS            = 3'd3,
        REG_CV_LOW_CURRENT_MA       = 3'd4,
        REG_CV_HIGH_CURRENT_MA      = 3'd5,
        REG_AUTO_THRESHOLD_DISABLED = 3'd6,
        REG_AUTO_THRESHOLD_ENABLED  = 3'd7
    } cfg_index_t;

    // Register values after reset.
    localparam logic        RST_EXTENDED_BALANCE_ON     = 1'b0;
    localparam logic [1:0]  RST_BALANCE_MODE            = 2'd2;
    localparam logic [15:0] RST_ENABLE_VOLTAGE_MV       = 16'd9950;
    localparam logic [7:0]  RST_CV_OFF_TICKS            = 8'd80;
    localparam logic [14:0] RST_CV_LOW_CURRENT_MA       = 15'd600;
    localparam logic [14:0] RST_CV_HIGH_CURRENT_MA      = 15'd1500;
    localparam logic [15:0] RST_AUTO_THRESHOLD_DISABLED = 16'd1150;
    localparam logic [15:0] RST_AUTO_THRESHOLD_ENABLED  = 16'd1650;

    // Width of the charge start wait counter.
    localparam int unsigned WAIT_W = 7;

    // Configuration register set.
    typedef struct packed {
        logic          extended_balance_on;
        balance_mode_t balance_mode;
        logic [15:0]   enable_voltage_mv;
        logic [7:0]    cv_off_ticks;
        logic [14:0]   cv_low_current_ma;
        logic [14:0]   cv_high_current_ma;
        logic [15:0]   auto_threshold_disabled;
        logic [15:0]   auto_threshold_enabled;
    } cfg_t;

    // One tick's input.
    typedef struct packed {
        charger_state_t     charger_state;
        logic [15:0]        battery_mv;
        logic signed [15:0] battery_ma;
        logic               typec_present;
        logic signed [15:0] sleep_ticks_left;
        logic               recharge_phase;
        logic               user_blocks_auto;
        logic [15:0]        unbalanced_centi_ah;
        logic [15:0]        force_load_ticks;
        logic               pin_write_ok;
    } tick_t;

    // One tick's result.
    typedef struct packed {
        logic balancer_on;
        logic pin_write;
        logic desired_level;
        logic auto_balance_request;
    } result_t;

endpackage

`default_nettype wire

>>> sv/cbec_if.sv
// Channel interfaces: tick input, result output and configuration write.
`default_nettype none

interface cbec_tick_if;
    logic               valid;
    logic               ready;
    logic [2:0]         charger_state;
    logic [15:0]        battery_mv;
    logic signed [15:0] battery_ma;
    logic               typec_present;
    logic signed [15:0] sleep_ticks_left;
    logic               recharge_phase;
    logic               user_blocks_auto;
    logic [15:0]        unbalanced_centi_ah;
    logic [15:0]        force_load_ticks;
    logic               pin_write_ok;

    modport source (
        output valid, charger_state, battery_mv, battery_ma, typec_present,
               sleep_ticks_left, recharge_phase, user_blocks_auto,
               unbalanced_centi_ah, force_load_ticks, pin_write_ok,
        input  ready
    );
    modport sink (
        input  valid, charger_state, battery_mv, battery_ma, typec_present,
               sleep_ticks_left, recharge_phase, user_blocks_auto,
               unbalanced_centi_ah, force_load_ticks, pin_write_ok,
        output ready
    );
endinterface

interface cbec_result_if;
    logic valid;
    logic ready;
    logic balancer_on;
    logic pin_write;
    logic desired_level;
    logic auto_balance_request;

    modport source (
        output valid, balancer_on, pin_write, desired_level, auto_balance_request,
        input  ready
    );
    modport sink (
        input  valid, balancer_on, pin_write, desired_level, auto_balance_request,
        output ready
    );
endinterface

interface cbec_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/cbec_cfg_regs.sv
// Configuration register file of the cell balancer enable control.
`default_nettype none

module cbec_cfg_regs (
    input  wire logic   clk,
    input  wire logic   rst_n,
    cbec_cfg_if.sink    cfg_ch,
    output cbec_pkg::cfg_t cfg
);
    import cbec_pkg::*;

    cfg_t cfg_reg;

    // Writes are always taken.
    assign cfg_ch.ready = 1'b1;
    assign cfg = cfg_reg;

    // Register writes, each field masked to its width.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.extended_balance_on     <= RST_EXTENDED_BALANCE_ON;
            cfg_reg.balance_mode            <= balance_mode_t'(RST_BALANCE_MODE);
            cfg_reg.enable_voltage_mv       <= RST_ENABLE_VOLTAGE_MV;
            cfg_reg.cv_off_ticks            <= RST_CV_OFF_TICKS;
            cfg_reg.cv_low_current_ma       <= RST_CV_LOW_CURRENT_MA;
            cfg_reg.cv_high_current_ma      <= RST_CV_HIGH_CURRENT_MA;
            cfg_reg.auto_threshold_disabled <= RST_AUTO_THRESHOLD_DISABLED;
            cfg_reg.auto_threshold_enabled  <= RST_AUTO_THRESHOLD_ENABLED;
        end
        else if (cfg_ch.valid)
        begin
            unique case (cfg_index_t'(cfg_ch.index))
                REG_EXTENDED_BALANCE_ON:
                    cfg_reg.extended_balance_on <= cfg_ch.data[0];
                REG_BALANCE_MODE:
                    cfg_reg.balance_mode <= balance_mode_t'(cfg_ch.data[1:0]);
                REG_ENABLE_VOLTAGE_MV:
                    cfg_reg.enable_voltage_mv <= cfg_ch.data;
                REG_CV_OFF_TICKS:
                    cfg_reg.cv_off_ticks <= cfg_ch.data[7:0];
                REG_CV_LOW_CURRENT_MA:
                    cfg_reg.cv_low_current_ma <= cfg_ch.data[14:0];
                REG_CV_HIGH_CURRENT_MA:
                    cfg_reg.cv_high_current_ma <= cfg_ch.data[14:0];
                REG_AUTO_THRESHOLD_DISABLED:
                    cfg_reg.auto_threshold_disabled <= cfg_ch.data;
                REG_AUTO_THRESHOLD_ENABLED:
                    cfg_reg.auto_threshold_enabled <= cfg_ch.data;
            endcase
        end
    end

endmodule

`default_nettype wire

>>> sv/cbec_core.sv
// Per-tick decision logic and the state that carries from tick to tick.
`default_nettype none

module cbec_core #(
    parameter int unsigned CHARGE_WAIT_TICKS = 80,
    parameter int unsigned SLEEP_GUARD_TICKS = 8
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire cbec_pkg::tick_t  tick,
    input  wire cbec_pkg::cfg_t   cfg,
    output cbec_pkg::result_t     res
);
    import cbec_pkg::*;

    localparam logic [WAIT_W-1:0] WAIT_LOAD = WAIT_W'(CHARGE_WAIT_TICKS);
    localparam logic signed [15:0] SLEEP_GUARD = $signed({8'd0, 8'(SLEEP_GUARD_TICKS)});

    // Carried state.
    logic [15:0]       force_count_reg, force_count_next;
    logic [7:0]        cv_count_reg, cv_count_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;
    logic              last_typec_reg, last_typec_next;
    logic              state_reg, state_next;

    // Tick locals.
    logic              low_v;
    logic [15:0]       force_eff;
    logic [15:0]       threshold;
    logic              request;
    balance_mode_t     mode;
    logic              desired;
    logic              use_cv;
    logic [16:0]       ma_mag;
    logic              cv_level;
    logic [7:0]        cv_count_upd;

    assign low_v = tick.battery_mv < cfg.enable_voltage_mv;
    assign force_eff = (tick.force_load_ticks != 16'd0) ? tick.force_load_ticks
                                                         : force_count_reg;
    assign threshold = (cfg.balance_mode == MODE_DISABLED) ? cfg.auto_threshold_disabled
                                                           : cfg.auto_threshold_enabled;

    // Extended balance: charge start wait and new USB-C connection check.
    always_comb
    begin
        wait_next = wait_reg;
        last_typec_next = last_typec_reg;
        request = 1'b0;
        if (cfg.extended_balance_on)
        begin
            if (tick.charger_state == CHG_STANDBY || tick.charger_state == CHG_DISCHARGING)
                wait_next = WAIT_LOAD;
            else if (wait_reg != '0)
                wait_next = wait_reg - 1'b1;
            if (!low_v && wait_next == '0 && last_typec_reg != tick.typec_present)
            begin
                last_typec_next = tick.typec_present;
                request = tick.typec_present && force_eff == 16'd0 &&
                          !tick.user_blocks_auto && tick.unbalanced_centi_ah >= threshold;
            end
        end
    end

    // Constant-voltage hysteresis, applied only when the decision reaches it.
    assign ma_mag = tick.battery_ma[15] ? 17'(-$signed({tick.battery_ma[15], tick.battery_ma}))
                                        : {1'b0, tick.battery_ma};
    always_comb
    begin
        cv_count_upd = cv_count_reg;
        cv_level = state_reg;
        if (state_reg)
        begin
            if (cv_count_reg == 8'd0)
                cv_level = 1'b0;
            else if (ma_mag < {2'b00, cfg.cv_low_current_ma})
                cv_count_upd = cv_count_reg - 1'b1;
            else if (cv_count_reg < cfg.cv_off_ticks)
                cv_count_upd = cv_count_reg + 1'b1;
        end
        else
        begin
            if (cv_count_reg >= cfg.cv_off_ticks)
                cv_level = 1'b1;
            else if ($signed({tick.battery_ma[15], tick.battery_ma}) >
                     $signed({2'b00, cfg.cv_high_current_ma}))
                cv_count_upd = cv_count_reg + 1'b1;
            else if (cv_count_reg != 8'd0)
                cv_count_upd = cv_count_reg - 1'b1;
        end
    end

    // Enable decision in priority order.
    always_comb
    begin
        mode = tick.recharge_phase ? MODE_CHARGE : cfg.balance_mode;
        force_count_next = force_eff;
        use_cv = 1'b0;
        desired = 1'b0;
        priority if (low_v)
            desired = 1'b0;
        else if (force_eff != 16'd0)
        begin
            force_count_next = force_eff - 1'b1;
            desired = 1'b1;
        end
        else if (tick.charger_state == CHG_STANDBY && tick.sleep_ticks_left < SLEEP_GUARD)
            desired = 1'b0;
        else
        begin
            unique case (mode)
                MODE_DISABLED:
                    desired = 1'b0;
                MODE_ALWAYS, MODE_CHARGE:
                begin
                    unique case (tick.charger_state)
                        CHG_PRECHARGE, CHG_CC: desired = 1'b1;
                        CHG_CV:
                        begin
                            use_cv = 1'b1;
                            desired = cv_level;
                        end
                        CHG_DONE: desired = 1'b0;
                        CHG_STANDBY, CHG_DISCHARGING, CHG_WAIT, CHG_OTHER:
                            desired = (mode == MODE_ALWAYS);
                    endcase
                end
                MODE_CHG_DISCHG:
                begin
                    unique case (tick.charger_state)
                        CHG_WAIT, CHG_DONE: desired = 1'b0;
                        CHG_CV:
                        begin
                            use_cv = 1'b1;
                            desired = cv_level;
                        end
                        CHG_STANDBY: desired = 1'b0;
                        CHG_DISCHARGING, CHG_PRECHARGE, CHG_CC, CHG_OTHER:
                            desired = 1'b1;
                    endcase
                end
            endcase
        end
    end

    // The state follows the desired level only when the pin write succeeds.
    assign cv_count_next = use_cv ? cv_count_upd : cv_count_reg;
    assign state_next = (state_reg != desired && tick.pin_write_ok) ? desired : state_reg;

    assign res.balancer_on = state_next;
    assign res.pin_write = state_reg != desired;
    assign res.desired_level = desired;
    assign res.auto_balance_request = request;

    // State registers advance once per tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_count_reg <= 16'd0;
            cv_count_reg    <= RST_CV_OFF_TICKS;
            wait_reg        <= WAIT_LOAD;
            last_typec_reg  <= 1'b0;
            state_reg       <= 1'b0;
        end
        else if (step)
        begin
            force_count_reg <= force_count_next;
            cv_count_reg    <= cv_count_next;
            wait_reg        <= wait_next;
            last_typec_reg  <= last_typec_next;
            state_reg       <= state_next;
        end
    end

    // A tick without a pin write leaves the balancer state as it was.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !res.pin_write |=> state_reg == $past(state_reg))
        else $error("balancer state changed without a pin write");

    // A failed pin write keeps the old state.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && !tick.pin_write_ok |=> state_reg == $past(state_reg))
        else $error("balancer state changed on a failed write");

    // An auto balance request needs the extended logic and USB-C present.
    assert property (@(posedge clk) disable iff (!rst_n)
        step && res.auto_balance_request |-> cfg.extended_balance_on && tick.typec_present)
        else $error("auto balance request without extended logic or USB-C");

    // The charge start wait never exceeds its load value.
    assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg <= WAIT_LOAD)
        else $error("charge start wait above its load value");

endmodule

`default_nettype wire

>>> sv/cell_balancer_enable_control_top.sv
// Top level of the cell balancer enable control.
//
//   channel    role    beat
//   tick_ch    sink    one tick of charger, battery and USB-C readings
//   result_ch  source  balancer state, pin write, desired level, auto request
//   cfg_ch     sink    one register write: index and data
//
// A tick passes an input register and a result register, with the decision
// logic between them. A new tick is accepted in every cycle unless the result
// stalls; the carried state updates as a tick moves from the input register
// into the result register.
// A stalled result holds the result register; the input register still
// accepts one more tick, after which ready drops until the result is taken.
// Reset clears the valid flags and loads the state and register reset values.
`default_nettype none

module cell_balancer_enable_control_top #(
    parameter int unsigned CHARGE_WAIT_TICKS = 80,
    parameter int unsigned SLEEP_GUARD_TICKS = 8
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    cbec_tick_if.sink      tick_ch,
    cbec_result_if.source  result_ch,
    cbec_cfg_if.sink       cfg_ch
);
    import cbec_pkg::*;

    cfg_t    cfg;
    tick_t   in_item_reg;
    logic    in_valid_reg;
    result_t out_res_reg;
    logic    out_valid_reg;
    result_t res;
    logic    advance;

    cbec_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_ch (cfg_ch),
        .cfg    (cfg)
    );

    cbec_core #(
        .CHARGE_WAIT_TICKS (CHARGE_WAIT_TICKS),
        .SLEEP_GUARD_TICKS (SLEEP_GUARD_TICKS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .tick  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // A tick moves on when the result register is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || result_ch.ready);
    assign tick_ch.ready = !in_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick_ch.ready)
            in_valid_reg <= tick_ch.valid;
    end

    always_ff @(posedge clk)
    begin
        if (tick_ch.valid && tick_ch.ready)
        begin
            in_item_reg.charger_state       <= charger_state_t'(tick_ch.charger_state);
            in_item_reg.battery_mv          <= tick_ch.battery_mv;
            in_item_reg.battery_ma          <= tick_ch.battery_ma;
            in_item_reg.typec_present       <= tick_ch.typec_present;
            in_item_reg.sleep_ticks_left    <= tick_ch.sleep_ticks_left;
            in_item_reg.recharge_phase      <= tick_ch.recharge_phase;
            in_item_reg.user_blocks_auto    <= tick_ch.user_blocks_auto;
            in_item_reg.unbalanced_centi_ah <= tick_ch.unbalanced_centi_ah;
            in_item_reg.force_load_ticks    <= tick_ch.force_load_ticks;
            in_item_reg.pin_write_ok        <= tick_ch.pin_write_ok;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || result_ch.ready)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            out_res_reg <= res;
    end

    assign result_ch.valid                = out_valid_reg;
    assign result_ch.balancer_on          = out_res_reg.balancer_on;
    assign result_ch.pin_write            = out_res_reg.pin_write;
    assign result_ch.desired_level        = out_res_reg.desired_level;
    assign result_ch.auto_balance_request = out_res_reg.auto_balance_request;

    // An accepted tick is held in the input register next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_ch.valid && tick_ch.ready |=> in_valid_reg)
        else $error("accepted tick lost from the input register");

    // A tick that moves on always produces a pending result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("tick advanced without a result");

    // A full input register with a stalled result keeps its tick.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && out_valid_reg && !result_ch.ready |=> in_valid_reg)
        else $error("tick dropped while the result stalled");

endmodule

`default_nettype wire

>>> tb/sv/cell_balancer_enable_control_top_test.sv
// Self-checking testbench for the cell balancer enable control top level.
`timescale 1ns / 100ps

module cell_balancer_enable_control_top_test;
    import cbec_pkg::*;

    localparam int unsigned WAIT_RELOAD     = 80;
    localparam int          SLEEP_GUARD     = 8;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned ITEMS_PER_PHASE = 205;
    localparam int unsigned RANDOM_PHASES   = 6;
    localparam int unsigned CYCLE_LIMIT     = 1000000;

    // One line of the directed plan: a register write or a tick.
    typedef struct packed {
        logic       is_reg;
        cfg_index_t idx;
        logic [15:0] val;
        tick_t      t;
        logic       typed;
        result_t    res;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cbec_tick_if   tick_ch ();
    cbec_result_if result_ch ();
    cbec_cfg_if    cfg_ch ();

    cell_balancer_enable_control_top #(
        .CHARGE_WAIT_TICKS(WAIT_RELOAD),
        .SLEEP_GUARD_TICKS(SLEEP_GUARD)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_ch  (tick_ch),
        .result_ch(result_ch),
        .cfg_ch   (cfg_ch)
    );

    // Local copy of the block's registers and carried state.
    cfg_t        cfg_m;
    logic [15:0] force_left;
    logic [7:0]  cv_count;
    logic [6:0]  start_wait;
    logic        prev_typec;
    logic        bal_on;

    // Outcomes owed by the block, oldest first.
    result_t     tick_outcomes[$];
    plan_row_t   plan[$];

    logic        calm = 1'b0;
    logic        drv_typec = 1'b0;
    int unsigned stall_left = 0;
    int unsigned errors = 0;
    int unsigned cycles = 0;
    int unsigned n_ticks = 0;
    int unsigned n_settings = 1;
    int unsigned n_pin_writes = 0;
    int unsigned n_refused = 0;
    int unsigned n_requests = 0;

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard limit on the run length.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones, none at all during calm stretches.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Constant-voltage hysteresis; updates the counter and returns the level.
    function automatic logic cv_hold(input logic signed [15:0] ma);
        int cur;
        int mag;
        cur = int'(ma);
        mag = (cur < 0) ? -cur : cur;
        if (bal_on)
        begin
            if (cv_count == 8'd0)
                return 1'b0;
            if (mag < int'(cfg_m.cv_low_current_ma))
                cv_count = cv_count - 8'd1;
            else if (cv_count < cfg_m.cv_off_ticks)
                cv_count = cv_count + 8'd1;
        end
        else
        begin
            if (cv_count >= cfg_m.cv_off_ticks)
                return 1'b1;
            if (cur > int'(cfg_m.cv_high_current_ma))
                cv_count = cv_count + 8'd1;
            else if (cv_count != 8'd0)
                cv_count = cv_count - 8'd1;
        end
        return bal_on;
    endfunction

    // Balancer decision for one tick; advances the carried state.
    function automatic result_t decide_tick(input tick_t t);
        result_t       r;
        logic          low_v;
        logic          want;
        logic          req;
        logic [15:0]   thr;
        balance_mode_t eff_mode;
        charger_state_t cs;
        want = 1'b0;
        req = 1'b0;
        cs = t.charger_state;
        low_v = t.battery_mv < cfg_m.enable_voltage_mv;
        if (t.force_load_ticks != 16'd0)
            force_left = t.force_load_ticks;

        // Extended balance request on a new USB-C connection.
        if (cfg_m.extended_balance_on)
        begin
            if (cs == CHG_STANDBY || cs == CHG_DISCHARGING)
                start_wait = 7'(WAIT_RELOAD);
            else if (start_wait != 7'd0)
                start_wait = start_wait - 7'd1;
            if (!low_v && start_wait == 7'd0 && prev_typec != t.typec_present)
            begin
                prev_typec = t.typec_present;
                if (t.typec_present && force_left == 16'd0)
                begin
                    thr = (cfg_m.balance_mode == MODE_DISABLED) ?
                          cfg_m.auto_threshold_disabled : cfg_m.auto_threshold_enabled;
                    req = !t.user_blocks_auto && (t.unbalanced_centi_ah >= thr);
                end
            end
        end

        // Desired enable level.
        eff_mode = t.recharge_phase ? MODE_CHARGE : cfg_m.balance_mode;
        if (low_v)
            want = 1'b0;
        else if (force_left != 16'd0)
        begin
            force_left = force_left - 16'd1;
            want = 1'b1;
        end
        else if (cs == CHG_STANDBY && int'($signed(t.sleep_ticks_left)) < SLEEP_GUARD)
            want = 1'b0;
        else if (eff_mode == MODE_DISABLED)
            want = 1'b0;
        else if (eff_mode != MODE_CHG_DISCHG)
        begin
            case (cs)
                CHG_PRECHARGE, CHG_CC: want = 1'b1;
                CHG_CV:                want = cv_hold(t.battery_ma);
                CHG_DONE:              want = 1'b0;
                default:               want = (eff_mode == MODE_ALWAYS);
            endcase
        end
        else
        begin
            case (cs)
                CHG_WAIT, CHG_DONE: want = 1'b0;
                CHG_CV:             want = cv_hold(t.battery_ma);
                default:            want = (cs != CHG_STANDBY);
            endcase
        end

        // Pin write when the level changes; the state follows only on success.
        r.pin_write = (bal_on != want);
        if (r.pin_write && t.pin_write_ok)
            bal_on = want;
        r.balancer_on = bal_on;
        r.desired_level = want;
        r.auto_balance_request = req;
        return r;
    endfunction

    // Random register set with moderate values.
    function automatic cfg_t random_settings(input logic ext);
        cfg_t c;
        c.extended_balance_on = ext;
        c.balance_mode = balance_mode_t'($urandom_range(0, 3));
        c.enable_voltage_mv = 16'($urandom_range(0, 20000));
        c.cv_off_ticks = 8'($urandom_range(1, 60));
        c.cv_low_current_ma = 15'($urandom_range(0, 2000));
        c.cv_high_current_ma = 15'($urandom_range(0, 3000));
        c.auto_threshold_disabled = 16'($urandom_range(0, 3000));
        c.auto_threshold_enabled = 16'($urandom_range(0, 3000));
        return c;
    endfunction

    // Random tick biased toward charging, thresholds and connection changes.
    function automatic tick_t random_tick();
        tick_t       t;
        int          v;
        logic [15:0] thr;
        t = '0;
        if (cfg_m.extended_balance_on && $urandom_range(0, 39) != 0)
            t.charger_state = charger_state_t'($urandom_range(2, 7));
        else if ($urandom_range(0, 2) == 0)
            t.charger_state = CHG_CV;
        else
            t.charger_state = charger_state_t'($urandom_range(0, 7));

        if (cfg_m.enable_voltage_mv != 16'd0 && $urandom_range(0, 7) == 0)
            t.battery_mv = 16'($urandom_range(0, int'(cfg_m.enable_voltage_mv) - 1));
        else
            t.battery_mv = 16'($urandom_range(int'(cfg_m.enable_voltage_mv), 65535));

        // Current near either CV threshold, small, or anywhere.
        case ($urandom_range(0, 3))
            0: v = int'($urandom_range(0, 65535)) - 32768;
            1: v = int'(cfg_m.cv_low_current_ma) * (($urandom_range(0, 1) == 0) ? 1 : -1)
                   + int'($urandom_range(0, 100)) - 50;
            2: v = int'(cfg_m.cv_high_current_ma) + int'($urandom_range(0, 200)) - 100;
            default: v = int'($urandom_range(0, 6000)) - 3000;
        endcase
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        t.battery_ma = 16'(v);

        if ($urandom_range(0, 3) == 0)
            t.sleep_ticks_left = 16'($urandom_range(0, 65535));
        else
            t.sleep_ticks_left = 16'(int'($urandom_range(0, 40)) - 20);

        if ($urandom_range(0, 11) == 0)
            drv_typec = !drv_typec;
        t.typec_present = drv_typec;
        t.recharge_phase = ($urandom_range(0, 7) == 0);
        t.user_blocks_auto = ($urandom_range(0, 3) == 0);

        // Unbalanced charge mostly close to the active threshold.
        thr = (cfg_m.balance_mode == MODE_DISABLED) ?
              cfg_m.auto_threshold_disabled : cfg_m.auto_threshold_enabled;
        v = int'(thr) + int'($urandom_range(0, 128)) - 64;
        if ($urandom_range(0, 3) == 0)
            v = int'($urandom_range(0, 65535));
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        t.unbalanced_centi_ah = 16'(v);

        t.force_load_ticks = ($urandom_range(0, 39) == 0) ? 16'($urandom_range(1, 24)) : 16'd0;
        t.pin_write_ok = ($urandom_range(0, 7) != 0);
        return t;
    endfunction

    function automatic plan_row_t row(input charger_state_t cs, input logic [15:0] mv,
                                      input logic [15:0] ma, input logic typec,
                                      input logic [15:0] sleep, input logic rech,
                                      input logic ub, input logic [15:0] unbal,
                                      input logic [15:0] load, input logic ok,
                                      input logic typed, input result_t res);
        plan_row_t p;
        p = '0;
        p.t.charger_state = cs;
        p.t.battery_mv = mv;
        p.t.battery_ma = ma;
        p.t.typec_present = typec;
        p.t.sleep_ticks_left = sleep;
        p.t.recharge_phase = rech;
        p.t.user_blocks_auto = ub;
        p.t.unbalanced_centi_ah = unbal;
        p.t.force_load_ticks = load;
        p.t.pin_write_ok = ok;
        p.typed = typed;
        p.res = res;
        return p;
    endfunction

    function automatic plan_row_t reg_row(input cfg_index_t idx, input logic [15:0] val);
        plan_row_t p;
        p = '0;
        p.is_reg = 1'b1;
        p.idx = idx;
        p.val = val;
        return p;
    endfunction

    // Drive one tick, wait for its beat and record the owed outcome.
    task automatic send_item(input tick_t t, input logic typed, input result_t typed_res);
        int unsigned idle;
        result_t     predicted;
        if (n_ticks % 64 == 0)
            calm = ($urandom_range(0, 2) == 0);
        idle = pick_gap();
        if (idle != 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        tick_ch.valid <= 1'b1;
        tick_ch.charger_state <= t.charger_state;
        tick_ch.battery_mv <= t.battery_mv;
        tick_ch.battery_ma <= t.battery_ma;
        tick_ch.typec_present <= t.typec_present;
        tick_ch.sleep_ticks_left <= t.sleep_ticks_left;
        tick_ch.recharge_phase <= t.recharge_phase;
        tick_ch.user_blocks_auto <= t.user_blocks_auto;
        tick_ch.unbalanced_centi_ah <= t.unbalanced_centi_ah;
        tick_ch.force_load_ticks <= t.force_load_ticks;
        tick_ch.pin_write_ok <= t.pin_write_ok;
        @(posedge clk);
        while (!tick_ch.ready)
            @(posedge clk);
        predicted = decide_tick(t);
        tick_outcomes.push_back(typed ? typed_res : predicted);
        n_ticks++;
        if (predicted.pin_write)
            n_pin_writes++;
        if (predicted.pin_write && !t.pin_write_ok)
            n_refused++;
        if (predicted.auto_balance_request)
            n_requests++;
    endtask

    // Stop sending and wait until every owed outcome has arrived.
    task automatic settle();
        tick_ch.valid <= 1'b0;
        @(posedge clk);
        while (tick_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write beat; the local copy follows at acceptance.
    task automatic write_reg(input cfg_index_t idx, input logic [15:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_EXTENDED_BALANCE_ON:     cfg_m.extended_balance_on = val[0];
            REG_BALANCE_MODE:            cfg_m.balance_mode = balance_mode_t'(val[1:0]);
            REG_ENABLE_VOLTAGE_MV:       cfg_m.enable_voltage_mv = val;
            REG_CV_OFF_TICKS:            cfg_m.cv_off_ticks = val[7:0];
            REG_CV_LOW_CURRENT_MA:       cfg_m.cv_low_current_ma = val[14:0];
            REG_CV_HIGH_CURRENT_MA:      cfg_m.cv_high_current_ma = val[14:0];
            REG_AUTO_THRESHOLD_DISABLED: cfg_m.auto_threshold_disabled = val;
            REG_AUTO_THRESHOLD_ENABLED:  cfg_m.auto_threshold_enabled = val;
            default: ;
        endcase
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic void check_field(input string name, input logic exp_v, input logic act_v);
        if (exp_v !== act_v)
        begin
            $error("%s mismatch: expected %0b, got %0b", name, exp_v, act_v);
            errors++;
        end
    endfunction

    // Result side stalls at random.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left != 0)
        begin
            result_ch.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            result_ch.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
                stall_left <= pick_gap();
        end
    end

    // Compare each result beat with the oldest owed outcome.
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (tick_outcomes.size() == 0)
            begin
                $error("result beat with no tick awaiting it");
                errors++;
            end
            else
            begin
                want = tick_outcomes.pop_front();
                check_field("balancer_on", want.balancer_on, result_ch.balancer_on);
                check_field("pin_write", want.pin_write, result_ch.pin_write);
                check_field("desired_level", want.desired_level, result_ch.desired_level);
                check_field("auto_balance_request", want.auto_balance_request,
                            result_ch.auto_balance_request);
            end
        end
    end

    // Stimulus: directed plan, then random phases under several register sets.
    initial
    begin : stimulus
        cfg_t        settings;
        tick_t       t;
        int unsigned phase;
        int unsigned i;

        tick_ch.valid = 1'b0;
        tick_ch.charger_state = 3'd0;
        tick_ch.battery_mv = 16'd0;
        tick_ch.battery_ma = 16'sd0;
        tick_ch.typec_present = 1'b0;
        tick_ch.sleep_ticks_left = 16'sd0;
        tick_ch.recharge_phase = 1'b0;
        tick_ch.user_blocks_auto = 1'b0;
        tick_ch.unbalanced_centi_ah = 16'd0;
        tick_ch.force_load_ticks = 16'd0;
        tick_ch.pin_write_ok = 1'b0;
        result_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_EXTENDED_BALANCE_ON;
        cfg_ch.data = 16'd0;

        // State after reset.
        cfg_m = {RST_EXTENDED_BALANCE_ON, balance_mode_t'(RST_BALANCE_MODE),
                 RST_ENABLE_VOLTAGE_MV, RST_CV_OFF_TICKS, RST_CV_LOW_CURRENT_MA,
                 RST_CV_HIGH_CURRENT_MA, RST_AUTO_THRESHOLD_DISABLED,
                 RST_AUTO_THRESHOLD_ENABLED};
        force_left = 16'd0;
        cv_count = RST_CV_OFF_TICKS;
        start_wait = 7'(WAIT_RELOAD);
        prev_typec = 1'b0;
        bal_on = 1'b0;

        // Result order in the typed values: on, pin write, desired, request.
        // Reset settings: low voltage, extremes, refused write, sleep guard.
        plan.push_back(row(CHG_STANDBY, 0, 'h8000, 0, 'h8000, 0, 0, 0, 0, 0, 1, 4'b0000));
        plan.push_back(row(CHG_CC, 'hFFFF, 'h7FFF, 1, 'h7FFF, 1, 1, 'hFFFF, 0, 1,
                           1, 4'b1110));
        plan.push_back(row(CHG_DONE, 'hFFFF, 0, 1, 100, 0, 0, 0, 0, 0, 1, 4'b1100));
        plan.push_back(row(CHG_DONE, 'hFFFF, 0, 1, 100, 0, 0, 0, 0, 1, 1, 4'b0100));
        plan.push_back(row(CHG_STANDBY, 'hFFFF, 0, 0, 7, 0, 0, 0, 0, 1, 1, 4'b0000));
        plan.push_back(row(CHG_STANDBY, 'hFFFF, 0, 0, 8, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_PRECHARGE, 12000, 100, 0, 8, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_CV, 12000, 0, 0, 8, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_CV, 12000, 'h8000, 0, 8, 1, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_WAIT, 12000, 0, 0, 8, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_CV, 12000, 0, 0, 8, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_OTHER, 12000, 0, 1, 8, 0, 1, 'hFFFF, 0, 1, 0, 4'b0000));
        // Force load, and the enable voltage boundary on either side.
        plan.push_back(row(CHG_STANDBY, 9950, 0, 1, 'h8000, 0, 0, 0, 1, 1, 1, 4'b1110));
        plan.push_back(row(CHG_CC, 9949, 0, 1, 100, 0, 0, 0, 0, 1, 1, 4'b0100));
        plan.push_back(row(CHG_DISCHARGING, 20000, -500, 0, 100, 0, 0, 0, 0, 1, 0, 4'b0000));
        // Disabled mode overridden by the recharge phase; zero CV hysteresis limit.
        plan.push_back(reg_row(REG_EXTENDED_BALANCE_ON, 1));
        plan.push_back(reg_row(REG_BALANCE_MODE, MODE_DISABLED));
        plan.push_back(reg_row(REG_ENABLE_VOLTAGE_MV, 0));
        plan.push_back(reg_row(REG_CV_OFF_TICKS, 0));
        plan.push_back(row(CHG_CC, 0, 0, 1, 100, 1, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_CC, 0, 0, 0, 100, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_CV, 0, 'h7FFF, 1, 100, 1, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_CV, 0, 0, 0, 100, 1, 0, 0, 0, 1, 0, 4'b0000));
        // Charge and discharge mode, then always mode.
        plan.push_back(reg_row(REG_BALANCE_MODE, MODE_CHG_DISCHG));
        plan.push_back(row(CHG_DISCHARGING, 5000, -900, 0, 100, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_WAIT, 5000, 0, 0, 100, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_STANDBY, 5000, 0, 0, 100, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(reg_row(REG_BALANCE_MODE, MODE_ALWAYS));
        plan.push_back(row(CHG_OTHER, 5000, 0, 0, 100, 0, 0, 0, 0, 1, 0, 4'b0000));
        plan.push_back(row(CHG_DONE, 5000, 0, 0, 100, 0, 0, 0, 0, 0, 0, 4'b0000));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed plan.
        for (i = 0; i < plan.size(); i++)
        begin
            if (plan[i].is_reg)
            begin
                settle();
                write_reg(plan[i].idx, plan[i].val);
                if (i + 1 < plan.size() && !plan[i + 1].is_reg)
                    n_settings++;
            end
            else
                send_item(plan[i].t, plan[i].typed, plan[i].res);
        end

        // Random phases, each under its own register set.
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                1: settings = {1'b1, MODE_CHG_DISCHG, 16'hFFFF, 8'hFF, 15'h7FFF, 15'h7FFF,
                               16'hFFFF, 16'hFFFF};
                2: settings = {1'b1, MODE_DISABLED, 16'h0000, 8'h00, 15'h0000, 15'h0000,
                               16'h0000, 16'h0000};
                default: settings = random_settings(phase != 3);
            endcase
            settle();
            write_reg(REG_EXTENDED_BALANCE_ON, 16'(settings.extended_balance_on));
            write_reg(REG_BALANCE_MODE, 16'(settings.balance_mode));
            write_reg(REG_ENABLE_VOLTAGE_MV, settings.enable_voltage_mv);
            write_reg(REG_CV_OFF_TICKS, 16'(settings.cv_off_ticks));
            write_reg(REG_CV_LOW_CURRENT_MA, 16'(settings.cv_low_current_ma));
            write_reg(REG_CV_HIGH_CURRENT_MA, 16'(settings.cv_high_current_ma));
            write_reg(REG_AUTO_THRESHOLD_DISABLED, settings.auto_threshold_disabled);
            write_reg(REG_AUTO_THRESHOLD_ENABLED, settings.auto_threshold_enabled);
            n_settings++;
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Halfway through, let the block drain completely once.
                if (i == ITEMS_PER_PHASE / 2)
                    settle();
                t = random_tick();
                // A full-scale force load near the very end wants the balancer on unless the voltage is low.
                if (phase == RANDOM_PHASES - 1 && i == ITEMS_PER_PHASE - 10)
                    t.force_load_ticks = 16'hFFFF;
                send_item(t, 1'b0, '0);
            end
        end

        settle();
        repeat (10) @(posedge clk);
        $display("Covered %0d ticks under %0d register settings, every mode and charger state.",
                 n_ticks, n_settings);
        $display("Saw %0d pin writes (%0d refused) and %0d auto-balance requests.",
                 n_pin_writes, n_refused, n_requests);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
